// ===== hdl/sector_cache_directory_top_defines.svh =====
// Assertion macros for the top-level file, which checks its own logic.
// Each macro takes a label, an enabling condition and an expected condition.
`ifndef SECTOR_CACHE_DIRECTORY_TOP_DEFINES_SVH
`define SECTOR_CACHE_DIRECTORY_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SCD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sector cache directory check failed");
`define SCD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sector cache directory check failed");
`else
`define SCD_ASSERT_NOW(lbl, ante, cons)
`define SCD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== hdl/scd_pkg.sv =====
`default_nettype none

package scd_pkg;

  localparam int TAG_W    = 23;
  localparam int ADDR_W   = 32;
  localparam int DATA_W   = 8;
  localparam int SEL_W    = 7;
  localparam int BYTE_W   = 9;
  localparam int LIDX_W   = 7;
  localparam int PERIOD_W = 16;
  localparam int RECIP_W  = 24;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd100;

  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_FLUSH = 2'd2,
    REQ_TICK  = 2'd3
  } req_t;

  // One request as it travels down the pipeline.
  typedef struct packed {
    req_t              req;
    logic [TAG_W-1:0]  sector;
    logic [BYTE_W-1:0] byte_idx;
    logic [DATA_W-1:0] data;
    logic [SEL_W-1:0]  sel;
  } item_t;

  // One result word.
  typedef struct packed {
    logic              hit;
    logic              wb_needed;
    logic [TAG_W-1:0]  wb_sector;
    logic              fill_needed;
    logic [TAG_W-1:0]  fill_sector;
    logic [LIDX_W-1:0] line_index;
    logic [BYTE_W-1:0] byte_index;
    logic              ram_write;
    logic [DATA_W-1:0] ram_write_data;
    logic              flush_due;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/scd_ram.sv =====
`default_nettype none

// Simple dual-port RAM, one write port and one registered read port.
module scd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hdl/scd_index.sv =====
`default_nettype none

// Front of the pipeline: request register, then the sector-to-line reduction.
// Outside flushes the line is sector mod NUM_LINES, as sector - q * NUM_LINES with q
// from a multiplication by a rounded-up reciprocal (exact for 23-bit sectors).
module scd_index #(
  parameter int NUM_LINES         = 127,
  parameter int SECTOR_BYTES_LOG2 = 9,
  localparam int LINE_W = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire scd_pkg::req_t                in_req,
  input  wire logic [scd_pkg::ADDR_W-1:0]   in_offset,
  input  wire logic [scd_pkg::DATA_W-1:0]   in_data,
  input  wire logic [scd_pkg::SEL_W-1:0]    in_sel,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output scd_pkg::item_t                    out_item,
  output logic      [LINE_W-1:0]            out_line
);

  localparam int TW   = scd_pkg::TAG_W;
  localparam int PW   = scd_pkg::TAG_W + scd_pkg::RECIP_W;
  localparam int KSH  = scd_pkg::TAG_W + $clog2(NUM_LINES);
  localparam logic [scd_pkg::RECIP_W-1:0] MREC = scd_pkg::RECIP_W'(
    ((64'd1 << KSH) + 64'(NUM_LINES) - 64'd1) / 64'(NUM_LINES));
  localparam int SXW  = LINE_W + scd_pkg::SEL_W;

  logic           a_v_r;
  scd_pkg::item_t a_item_r;
  logic           b_v_r;
  scd_pkg::item_t b_item_r;
  logic [TW-1:0]  b_quot_r;

  logic           a_free;
  logic           b_free;
  logic [PW-1:0]  a_prod;
  logic [TW-1:0]  b_rem;
  logic [SXW-1:0] b_sel_ext;

  assign b_free   = !b_v_r || out_ready;
  assign a_free   = !a_v_r || b_free;
  assign in_ready = a_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else begin
      if (a_free) begin
        a_v_r <= in_valid;
      end
      if (b_free) begin
        b_v_r <= a_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && a_free) begin
      a_item_r.req      <= in_req;
      a_item_r.sector   <= TW'(in_offset >> SECTOR_BYTES_LOG2);
      a_item_r.byte_idx <= in_offset[scd_pkg::BYTE_W-1:0];
      a_item_r.data     <= in_data;
      a_item_r.sel      <= in_sel;
    end
    if (a_v_r && b_free) begin
      b_item_r <= a_item_r;
      b_quot_r <= TW'(a_prod >> KSH);
    end
  end

  assign a_prod    = PW'(a_item_r.sector) * PW'(MREC);
  assign b_rem     = b_item_r.sector - TW'(b_quot_r * TW'(NUM_LINES));
  assign b_sel_ext = SXW'(b_item_r.sel);

  always_comb begin
    case (b_item_r.req)
      scd_pkg::REQ_FLUSH: out_line = b_sel_ext[LINE_W-1:0];
      default:            out_line = b_rem[LINE_W-1:0];
    endcase
  end

  assign out_valid = b_v_r;
  assign out_item  = b_item_r;

endmodule

`default_nettype wire

// ===== hdl/scd_dir.sv =====
`default_nettype none

// Directory stage: tag lookup and update, valid and dirty bits, tick counter
// and the result register.
module scd_dir #(
  parameter int NUM_LINES = 127,
  localparam int LINE_W = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire scd_pkg::item_t                 in_item,
  input  wire logic [LINE_W-1:0]              in_line,
  input  wire logic                           cfg_valid,
  input  wire logic [scd_pkg::PERIOD_W-1:0]   cfg_period,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output scd_pkg::result_t                    out_res
);

  localparam int TW = scd_pkg::TAG_W;
  localparam int CW = scd_pkg::PERIOD_W;

  logic                 c_v_r;
  scd_pkg::item_t       c_item_r;
  logic [LINE_W-1:0]    c_line_r;
  logic                 o_v_r;
  scd_pkg::result_t     o_res_r;
  logic [NUM_LINES-1:0] line_valid_r;
  logic [NUM_LINES-1:0] line_dirty_r;
  logic [CW-1:0]        tick_r;
  logic [CW-1:0]        tick_nxt;
  logic [CW-1:0]        period_r;
  logic                 byp_v_r;
  logic [LINE_W-1:0]    byp_line_r;
  logic [TW-1:0]        byp_tag_r;

  logic                 o_free;
  logic                 c_fire;
  logic                 c_load;
  logic [TW-1:0]        ram_tag;
  logic [TW-1:0]        tag_cur;
  logic                 is_access;
  logic                 is_write;
  logic                 is_flush;
  logic                 is_tick;
  logic                 sel_ok;
  logic                 cur_valid;
  logic                 cur_dirty;
  logic                 hit;
  logic                 tag_we;
  logic                 flush_clean;
  logic [CW-1:0]        tick_inc;
  scd_pkg::result_t     res;

  assign o_free   = !o_v_r || out_ready;
  assign c_fire   = c_v_r && o_free;
  assign in_ready = !c_v_r || o_free;
  assign c_load   = in_valid && in_ready;

  scd_ram #(
    .WIDTH (TW),
    .DEPTH (NUM_LINES)
  ) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (c_line_r),
    .wdata (c_item_r.sector),
    .re    (c_load),
    .raddr (in_line),
    .rdata (ram_tag)
  );

  // A tag written on the same edge as the read of the next word is forwarded.
  assign tag_cur = (byp_v_r && byp_line_r == c_line_r) ? byp_tag_r : ram_tag;

  always_comb begin
    is_access = 1'b0;
    is_write  = 1'b0;
    is_flush  = 1'b0;
    is_tick   = 1'b0;
    case (c_item_r.req)
      scd_pkg::REQ_READ: begin
        is_access = 1'b1;
      end
      scd_pkg::REQ_WRITE: begin
        is_access = 1'b1;
        is_write  = 1'b1;
      end
      scd_pkg::REQ_FLUSH: begin
        is_flush = 1'b1;
      end
      default: begin
        is_tick = 1'b1;
      end
    endcase
  end

  assign sel_ok    = 32'(c_item_r.sel) < NUM_LINES;
  assign cur_valid = line_valid_r[c_line_r];
  assign cur_dirty = line_dirty_r[c_line_r];
  assign hit       = is_access && cur_valid && (tag_cur == c_item_r.sector);
  assign tag_we    = c_fire && is_access && !hit;
  assign flush_clean = is_flush && sel_ok && cur_dirty;

  assign tick_inc = tick_r + CW'(1);
  assign tick_nxt = (period_r != '0 && tick_inc >= period_r) ? '0 : tick_inc;

  always_comb begin
    res = '0;
    if (is_access) begin
      res.hit         = hit;
      res.wb_needed   = !hit && cur_valid && cur_dirty;
      res.fill_needed = !hit;
      res.line_index  = scd_pkg::LIDX_W'(c_line_r);
      res.byte_index  = c_item_r.byte_idx;
      res.ram_write   = is_write;
      if (!hit) begin
        res.fill_sector = c_item_r.sector;
      end
      if (!hit && cur_valid && cur_dirty) begin
        res.wb_sector = tag_cur;
      end
      if (is_write) begin
        res.ram_write_data = c_item_r.data;
      end
    end else if (is_flush) begin
      res.line_index = c_item_r.sel;
      res.wb_needed  = flush_clean;
      if (flush_clean) begin
        res.wb_sector = tag_cur;
      end
    end else if (is_tick) begin
      res.flush_due = (tick_nxt == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r        <= 1'b0;
      o_v_r        <= 1'b0;
      byp_v_r      <= 1'b0;
      line_valid_r <= '0;
      line_dirty_r <= '0;
      tick_r       <= '0;
      period_r     <= scd_pkg::PERIOD_RESET;
    end else begin
      if (in_ready) begin
        c_v_r <= in_valid;
      end
      if (o_free) begin
        o_v_r <= c_fire;
      end
      if (c_load) begin
        byp_v_r <= tag_we;
      end
      if (cfg_valid) begin
        period_r <= cfg_period;
      end
      if (c_fire) begin
        if (is_access) begin
          line_valid_r[c_line_r] <= 1'b1;
          line_dirty_r[c_line_r] <= is_write || (hit && cur_dirty);
        end
        if (flush_clean) begin
          line_dirty_r[c_line_r] <= 1'b0;
        end
        if (is_tick) begin
          tick_r <= tick_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (c_load) begin
      c_item_r   <= in_item;
      c_line_r   <= in_line;
      byp_line_r <= c_line_r;
      byp_tag_r  <= c_item_r.sector;
    end
    if (c_fire) begin
      o_res_r <= res;
    end
  end

  assign out_valid = o_v_r;
  assign out_res   = o_res_r;

endmodule

`default_nettype wire

// ===== hdl/sector_cache_directory_top.sv =====
`default_nettype none

// Channel  | Handshake             | Word
// ---------+-----------------------+------------------------------------------
// in_      | in_valid / in_ready   | req_type, byte_offset, write_data,
//          |                       | line_select
// out_     | out_valid / out_ready | hit, write-back and fill requests, line
//          |                       | and byte position, data write, flush_due
// cfg_     | cfg_valid / cfg_ready | writeback_period
//
// One word is accepted per cycle when the result side keeps up.
// The path is four registers deep: request register, reciprocal product,
// tag RAM read, result register. The tag RAM read port sets the lookup stage.
// Reset clears all valid and dirty bits, the tick counter and the pipeline
// at once; no clearing pass is needed and words are taken right after reset.
// A stalled result holds the result register, and the stages behind it fill
// up before in_ready drops.
`include "sector_cache_directory_top_defines.svh"

module sector_cache_directory_top #(
  parameter int NUM_LINES         = 127,
  parameter int SECTOR_BYTES_LOG2 = 9
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // Request words.
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [1:0]                       in_req_type,
  input  wire logic [scd_pkg::ADDR_W-1:0]       in_byte_offset,
  input  wire logic [scd_pkg::DATA_W-1:0]       in_write_data,
  input  wire logic [scd_pkg::SEL_W-1:0]        in_line_select,
  // Result words.
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  out_hit,
  output logic                                  out_writeback_needed,
  output logic      [scd_pkg::TAG_W-1:0]        out_writeback_sector,
  output logic                                  out_fill_needed,
  output logic      [scd_pkg::TAG_W-1:0]        out_fill_sector,
  output logic      [scd_pkg::LIDX_W-1:0]       out_line_index,
  output logic      [scd_pkg::BYTE_W-1:0]       out_byte_index,
  output logic                                  out_ram_write,
  output logic      [scd_pkg::DATA_W-1:0]       out_ram_write_data,
  output logic                                  out_flush_due,
  // Configuration writes.
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [scd_pkg::PERIOD_W-1:0]     cfg_writeback_period
);

  localparam int LINE_W = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;

  logic              b_valid;
  logic              b_ready;
  scd_pkg::item_t    b_item;
  logic [LINE_W-1:0] b_line;
  scd_pkg::result_t  res;

  // Period register written when asked; user, not block, ensures it is idle.
  assign cfg_ready = 1'b1;

  // Front end: request register and the sector-to-line reduction.
  scd_index #(
    .NUM_LINES         (NUM_LINES),
    .SECTOR_BYTES_LOG2 (SECTOR_BYTES_LOG2)
  ) u_index (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (scd_pkg::req_t'(in_req_type)),
    .in_offset (in_byte_offset),
    .in_data   (in_write_data),
    .in_sel    (in_line_select),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .out_item  (b_item),
    .out_line  (b_line)
  );

  // Directory: tag RAM, line state, tick counter and the result register.
  scd_dir #(
    .NUM_LINES (NUM_LINES)
  ) u_dir (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (b_valid),
    .in_ready   (b_ready),
    .in_item    (b_item),
    .in_line    (b_line),
    .cfg_valid  (cfg_valid),
    .cfg_period (cfg_writeback_period),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_res    (res)
  );

  assign out_hit              = res.hit;
  assign out_writeback_needed = res.wb_needed;
  assign out_writeback_sector = res.wb_sector;
  assign out_fill_needed      = res.fill_needed;
  assign out_fill_sector      = res.fill_sector;
  assign out_line_index       = res.line_index;
  assign out_byte_index       = res.byte_index;
  assign out_ram_write        = res.ram_write;
  assign out_ram_write_data   = res.ram_write_data;
  assign out_flush_due        = res.flush_due;

  // The reduced line of a read or write always lands inside the cache.
  `SCD_ASSERT_NOW(a_line_in_range, b_valid && (b_item.req == scd_pkg::REQ_READ || b_item.req == scd_pkg::REQ_WRITE), 32'(b_line) < NUM_LINES)
  // A fill is only asked for on a miss.
  `SCD_ASSERT_NOW(a_fill_on_miss, out_valid && out_fill_needed, !out_hit)
  // A data write always lands in a line that hit or is being filled.
  `SCD_ASSERT_NOW(a_write_has_line, out_valid && out_ram_write, out_hit || out_fill_needed)
  // A flush-due word comes from a tick and carries no access result.
  `SCD_ASSERT_NOW(a_tick_alone, out_valid && out_flush_due, !out_hit && !out_fill_needed && !out_writeback_needed && !out_ram_write)

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none

// Self-checking bench for the sector cache directory.
//
// An initial block sequences the run: it resets the block, writes the
// write-back period register between phases while the block is idle, and
// fills a queue of pending request words. A clocked driver takes words from
// that queue and offers them on the in_ channel. A clocked monitor drives
// out_ready and checks every accepted result word against a queue of
// expected words. Expected words are computed at the moment a request word
// is accepted, by a directory model kept inside this bench.
module tb;
  import scd_pkg::*;

  localparam int NUM_LINES   = 127;
  localparam int SECTOR_LOG2 = 9;
  // Cycles without any accepted word before the run is declared hung.
  localparam int HANG_LIMIT  = 2000;

  // One request word as the bench sees it.
  typedef struct {
    req_t               kind;
    logic [ADDR_W-1:0]  addr;
    logic [DATA_W-1:0]  data;
    logic [SEL_W-1:0]   sel;
  } access_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [1:0]          in_req_type = REQ_READ;
  logic [ADDR_W-1:0]   in_byte_offset = '0;
  logic [DATA_W-1:0]   in_write_data = '0;
  logic [SEL_W-1:0]    in_line_select = '0;

  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                out_hit;
  logic                out_writeback_needed;
  logic [TAG_W-1:0]    out_writeback_sector;
  logic                out_fill_needed;
  logic [TAG_W-1:0]    out_fill_sector;
  logic [LIDX_W-1:0]   out_line_index;
  logic [BYTE_W-1:0]   out_byte_index;
  logic                out_ram_write;
  logic [DATA_W-1:0]   out_ram_write_data;
  logic                out_flush_due;

  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [PERIOD_W-1:0] cfg_writeback_period = PERIOD_RESET;

  sector_cache_directory_top #(
    .NUM_LINES        (NUM_LINES),
    .SECTOR_BYTES_LOG2(SECTOR_LOG2)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_req_type         (in_req_type),
    .in_byte_offset      (in_byte_offset),
    .in_write_data       (in_write_data),
    .in_line_select      (in_line_select),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_hit             (out_hit),
    .out_writeback_needed(out_writeback_needed),
    .out_writeback_sector(out_writeback_sector),
    .out_fill_needed     (out_fill_needed),
    .out_fill_sector     (out_fill_sector),
    .out_line_index      (out_line_index),
    .out_byte_index      (out_byte_index),
    .out_ram_write       (out_ram_write),
    .out_ram_write_data  (out_ram_write_data),
    .out_flush_due       (out_flush_due),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_writeback_period(cfg_writeback_period)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The bench's own copy of the directory state and of the period register.
  logic [TAG_W-1:0]    dir_tag [NUM_LINES];
  bit                  dir_valid [NUM_LINES];
  bit                  dir_dirty [NUM_LINES];
  logic [PERIOD_W-1:0] tick_count_model;
  logic [PERIOD_W-1:0] period_model = PERIOD_RESET;

  access_t   access_queue[$];
  result_t   expected_results[$];
  access_t   word_on_bus;

  // A handful of sectors that most random accesses revolve around, so that
  // hits, conflicts with dirty victims and useful flushes all happen often.
  logic [TAG_W-1:0] hot_sectors [8];

  bit idle_on = 1'b1;
  int send_gap = 0;
  int stall_left = 0;
  int quiet_cycles = 0;
  int mismatches = 0;
  int words_sent = 0;
  int n_hits = 0, n_misses = 0, n_writebacks = 0, n_flushes = 0, n_flush_due = 0;
  int n_cfg_writes = 0;

  // Updates the directory model with one accepted request word and returns
  // the result word that the block has to produce for it.
  function automatic result_t lookup_directory(access_t a);
    result_t          r;
    logic [TAG_W-1:0] sector;
    int               line;
    logic [PERIOD_W-1:0] next_count;
    r = '0;
    case (a.kind)
      REQ_READ, REQ_WRITE: begin
        sector = TAG_W'(a.addr >> SECTOR_LOG2);
        line = sector % NUM_LINES;
        r.hit = dir_valid[line] && (dir_tag[line] == sector);
        if (r.hit) begin
          n_hits++;
        end else begin
          n_misses++;
          // A miss evicts the current line; only a valid dirty one goes back.
          if (dir_valid[line] && dir_dirty[line]) begin
            r.wb_needed = 1'b1;
            r.wb_sector = dir_tag[line];
            n_writebacks++;
          end
          r.fill_needed = 1'b1;
          r.fill_sector = sector;
          dir_tag[line] = sector;
          dir_valid[line] = 1'b1;
          dir_dirty[line] = 1'b0;
        end
        r.line_index = LIDX_W'(line);
        r.byte_index = a.addr[BYTE_W-1:0];
        if (a.kind == REQ_WRITE) begin
          r.ram_write = 1'b1;
          r.ram_write_data = a.data;
          dir_dirty[line] = 1'b1;
        end
      end
      REQ_FLUSH: begin
        n_flushes++;
        r.line_index = a.sel;
        // A line number past the end of the cache reports no write-back.
        if (a.sel < NUM_LINES && dir_dirty[a.sel]) begin
          r.wb_needed = 1'b1;
          r.wb_sector = dir_tag[a.sel];
          dir_dirty[a.sel] = 1'b0;
          n_writebacks++;
        end
      end
      default: begin
        next_count = tick_count_model + 1'b1;
        if (period_model != '0 && next_count >= period_model) next_count = '0;
        tick_count_model = next_count;
        r.flush_due = (next_count == '0);
        if (r.flush_due) n_flush_due++;
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
  endtask

  task automatic push_access(req_t k, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] d,
                             logic [SEL_W-1:0] s);
    access_t a;
    a.kind = k;
    a.addr = addr;
    a.data = d;
    a.sel  = s;
    access_queue.push_back(a);
  endtask

  // Mostly accesses around the hot sectors, some fully random addresses.
  // Every field carries random content whatever the request type.
  function automatic access_t random_access();
    access_t          a;
    int unsigned      pick;
    logic [TAG_W-1:0] sector;
    pick = $urandom_range(0, 99);
    a.kind = (pick < 35) ? REQ_READ : (pick < 70) ? REQ_WRITE :
             (pick < 85) ? REQ_FLUSH : REQ_TICK;
    if ($urandom_range(0, 9) < 7)
      sector = hot_sectors[$urandom_range(0, 7)] + TAG_W'(NUM_LINES * $urandom_range(0, 3));
    else
      sector = TAG_W'($urandom);
    a.addr = {sector, BYTE_W'($urandom)};
    a.data = DATA_W'($urandom);
    if ($urandom_range(0, 9) < 7)
      a.sel = SEL_W'(hot_sectors[$urandom_range(0, 7)] % NUM_LINES);
    else
      a.sel = SEL_W'($urandom_range(0, 127));
    return a;
  endfunction

  // Waits until every queued word has been sent and every result has come.
  // Checks happen on the falling edge, when all clocked updates have settled.
  task automatic wait_quiet();
    do @(negedge clk);
    while (access_queue.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  // Register write; only called with the block idle.
  task automatic set_period(logic [PERIOD_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_writeback_period <= value;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    period_model = value;
    n_cfg_writes++;
  endtask

  task automatic run_random(int count);
    for (int i = 0; i < 8; i++) hot_sectors[i] = TAG_W'($urandom);
    // Keep the top of the sector range in play now and then.
    if ($urandom_range(0, 1) == 1) hot_sectors[0] = '1;
    for (int i = 0; i < count; i++) access_queue.push_back(random_access());
    wait_quiet();
  endtask

  // Driver: offers queued words, inserting random gaps between them while
  // idle_on is set. A word that has been offered stays put until accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(lookup_directory(word_on_bus));
        words_sent++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (access_queue.size() == 0) begin
          in_valid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 11) == 0) begin
          send_gap = $urandom_range(0, 18);
          in_valid <= 1'b0;
        end else begin
          word_on_bus = access_queue.pop_front();
          in_valid <= 1'b1;
          in_req_type <= word_on_bus.kind;
          in_byte_offset <= word_on_bus.addr;
          in_write_data <= word_on_bus.data;
          in_line_select <= word_on_bus.sel;
        end
      end
    end
  end

  // Monitor: random back-pressure bursts, and a field by
  // field comparison of each accepted result word with the oldest expected one.
  result_t seen_word, want_word;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        seen_word.hit            = out_hit;
        seen_word.wb_needed      = out_writeback_needed;
        seen_word.wb_sector      = out_writeback_sector;
        seen_word.fill_needed    = out_fill_needed;
        seen_word.fill_sector    = out_fill_sector;
        seen_word.line_index     = out_line_index;
        seen_word.byte_index     = out_byte_index;
        seen_word.ram_write      = out_ram_write;
        seen_word.ram_write_data = out_ram_write_data;
        seen_word.flush_due      = out_flush_due;
        if (expected_results.size() == 0) begin
          report_mismatch("result word arrived with no request outstanding");
        end else begin
          want_word = expected_results.pop_front();
          check_field("hit", seen_word.hit, want_word.hit);
          check_field("writeback_needed", seen_word.wb_needed, want_word.wb_needed);
          check_field("writeback_sector", seen_word.wb_sector, want_word.wb_sector);
          check_field("fill_needed", seen_word.fill_needed, want_word.fill_needed);
          check_field("fill_sector", seen_word.fill_sector, want_word.fill_sector);
          check_field("line_index", seen_word.line_index, want_word.line_index);
          check_field("byte_index", seen_word.byte_index, want_word.byte_index);
          check_field("ram_write", seen_word.ram_write, want_word.ram_write);
          check_field("ram_write_data", seen_word.ram_write_data, want_word.ram_write_data);
          check_field("flush_due", seen_word.flush_due, want_word.flush_due);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 15) == 0) begin
        stall_left = $urandom_range(0, 18);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: any accepted word on any channel restarts the count.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", HANG_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < NUM_LINES; i++) begin
      dir_tag[i] = '0;
      dir_valid[i] = 1'b0;
      dir_dirty[i] = 1'b0;
    end
    tick_count_model = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words, with the period at its reset value.
    // A read miss on an empty line, then a write hit at the last byte.
    push_access(REQ_READ,  32'h0000_0000, 8'h00, 7'd0);
    push_access(REQ_WRITE, 32'h0000_01FF, 8'hFF, 7'd127);
    // Another sector on the same line evicts the dirty one.
    push_access(REQ_WRITE, {23'd127, 9'd0}, 8'h00, 7'd0);
    // The highest address: top sector, miss and then a write hit.
    push_access(REQ_READ,  32'hFFFF_FFFF, 8'hFF, 7'd127);
    push_access(REQ_WRITE, 32'hFFFF_FFFF, 8'hA5, 7'd0);
    // A dirty flush, then the same line again now clean.
    push_access(REQ_FLUSH, 32'hFFFF_FFFF, 8'hFF, SEL_W'(23'h7F_FFFF % NUM_LINES));
    push_access(REQ_FLUSH, 32'h0000_0000, 8'h00, SEL_W'(23'h7F_FFFF % NUM_LINES));
    // A line number past the end of the cache, a line never filled, and dirty line 0.
    push_access(REQ_FLUSH, 32'h5555_5555, 8'h55, 7'd127);
    push_access(REQ_FLUSH, 32'hAAAA_AAAA, 8'hAA, 7'd5);
    push_access(REQ_FLUSH, 32'h0000_0000, 8'h00, 7'd0);
    // A clean hit, and a miss whose victim is valid but clean.
    push_access(REQ_READ,  {23'd127, 9'h100}, 8'h00, 7'd0);
    push_access(REQ_READ,  32'h0000_0155, 8'h00, 7'd0);
    // Alternating bit patterns through every field.
    push_access(REQ_WRITE, 32'h5555_5555, 8'h5A, 7'h55);
    push_access(REQ_WRITE, 32'hAAAA_AAAA, 8'hA5, 7'h2A);
    push_access(REQ_READ,  32'h5555_5555, 8'h00, 7'h00);
    push_access(REQ_READ,  32'hAAAA_AAAA, 8'hFF, 7'h7F);
    push_access(REQ_TICK,  32'hFFFF_FFFF, 8'hFF, 7'h7F);
    push_access(REQ_TICK,  32'h0000_0000, 8'h00, 7'h00);
    push_access(REQ_TICK,  32'h1234_5678, 8'h3C, 7'h11);
    wait_quiet();

    // Random phases; each one ends with the sender held until every result
    // is back, and the register is only written at those points.
    run_random(300);
    set_period(16'd1);
    run_random(300);
    set_period(16'hFFFF);
    run_random(300);
    // Lowering the period below the running count forces an early wrap.
    set_period(PERIOD_W'($urandom_range(2, 40)));
    run_random(150);
    run_random(150);
    set_period(PERIOD_W'($urandom_range(41, 1000)));
    run_random(400);
    // The last phase runs flat out on both sides.
    idle_on = 1'b0;
    set_period(16'd3);
    run_random(400);

    repeat (10) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d expected result words never arrived",
                                expected_results.size()));
    $display("covered %0d request words and %0d period writes: %0d hits, %0d misses",
             words_sent, n_cfg_writes, n_hits, n_misses);
    $display("with %0d write-backs, %0d flush words and %0d periodic flush flags",
             n_writebacks, n_flushes, n_flush_due);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
